[hdl/irtpd_pkg.sv]
// Package for the interleaved RTP deframer: frame phase codes, register
// indexes, reset values and the result item struct.
// No dependencies.
package irtpd_pkg;

   localparam logic [7:0] MAGIC_BYTE      = 8'h24;
   localparam int unsigned CSR_INDEX_WIDTH = 3;

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VIDEO_DATA    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VIDEO_CONTROL = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AUDIO_DATA    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AUDIO_CONTROL = 3'd3;

   localparam logic [7:0] VIDEO_DATA_RESET    = 8'd0;
   localparam logic [7:0] VIDEO_CONTROL_RESET = 8'd1;
   localparam logic [7:0] AUDIO_DATA_RESET    = 8'd2;
   localparam logic [7:0] AUDIO_CONTROL_RESET = 8'd3;

   localparam logic MEDIA_VIDEO = 1'b0;
   localparam logic MEDIA_AUDIO = 1'b1;

   typedef enum logic [4:0] {
      PHASE_HUNT    = 5'b00001,
      PHASE_CHANNEL = 5'b00010,
      PHASE_LEN_HI  = 5'b00100,
      PHASE_LEN_LO  = 5'b01000,
      PHASE_PAYLOAD = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        media_kind;
      logic        is_control;
      logic        first_of_packet;
      logic        last_of_packet;
      logic        empty_packet;
      logic [15:0] packet_length;
   } rsp_item_type;

endpackage

[hdl/interleaved_rtp_deframer_unit.sv]
// Interleaved RTP/RTCP binary-data deframer, top level.
// Depends on irtpd_pkg for phase codes, register indexes and the result struct.
// An accepted payload byte's result is registered into the main or the skid entry.
// Throughput: one byte per cycle; a two-entry output register (main plus skid)
// keeps input flowing while one result waits, and req_stall rises when both are full.
// Reset (synchronous, active high): phase returns to hunting for the magic byte,
// channel registers take their default values and both output entries empty.
module interleaved_rtp_deframer_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_in_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_payload_byte,
   output logic                                  rsp_media_kind,
   output logic                                  rsp_is_control,
   output logic                                  rsp_first_of_packet,
   output logic                                  rsp_last_of_packet,
   output logic                                  rsp_empty_packet,
   output logic [15:0]                           rsp_packet_length,
   input  logic                                  csr_write_enable,
   input  logic [irtpd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                            csr_write_data
);

   logic [7:0] video_data_ff, video_control_ff, audio_data_ff, audio_control_ff;

   irtpd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  held_channel_ff, held_channel_in;
   logic [15:0] held_length_ff, held_length_in;
   logic [15:0] bytes_left_ff, bytes_left_in;

   irtpd_pkg::rsp_item_type main_ff, skid_ff, result;
   logic main_valid_ff, skid_valid_ff;
   logic has_result;
   logic accept;
   logic routed, kind, ctrl;
   logic [15:0] full_length;
   logic last_byte;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         video_data_ff    <= irtpd_pkg::VIDEO_DATA_RESET;
         video_control_ff <= irtpd_pkg::VIDEO_CONTROL_RESET;
         audio_data_ff    <= irtpd_pkg::AUDIO_DATA_RESET;
         audio_control_ff <= irtpd_pkg::AUDIO_CONTROL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            irtpd_pkg::CSR_VIDEO_DATA:    video_data_ff    <= csr_write_data;
            irtpd_pkg::CSR_VIDEO_CONTROL: video_control_ff <= csr_write_data;
            irtpd_pkg::CSR_AUDIO_DATA:    audio_data_ff    <= csr_write_data;
            irtpd_pkg::CSR_AUDIO_CONTROL: audio_control_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // channel routing; video wins over audio when registers overlap
   always_comb begin
      routed = 1'b1;
      kind   = irtpd_pkg::MEDIA_VIDEO;
      ctrl   = 1'b0;
      if (held_channel_ff == video_data_ff || held_channel_ff == video_control_ff) begin
         ctrl = (held_channel_ff == video_control_ff);
      end else if (held_channel_ff == audio_data_ff ||
                   held_channel_ff == audio_control_ff) begin
         kind = irtpd_pkg::MEDIA_AUDIO;
         ctrl = (held_channel_ff == audio_control_ff);
      end else begin
         routed = 1'b0;
      end
   end

   assign full_length = {held_length_ff[15:8], req_in_byte};
   assign last_byte   = (bytes_left_ff[15:1] == 15'd0);

   always_comb begin
      phase_in        = phase_ff;
      held_channel_in = held_channel_ff;
      held_length_in  = held_length_ff;
      bytes_left_in   = bytes_left_ff;
      has_result      = 1'b0;
      result.payload_byte    = req_in_byte;
      result.media_kind      = kind;
      result.is_control      = ctrl;
      result.first_of_packet = (bytes_left_ff == held_length_ff);
      result.last_of_packet  = last_byte;
      result.empty_packet    = 1'b0;
      result.packet_length   = held_length_ff;
      case (phase_ff)
         irtpd_pkg::PHASE_CHANNEL: begin
            held_channel_in = req_in_byte;
            phase_in        = irtpd_pkg::PHASE_LEN_HI;
         end
         irtpd_pkg::PHASE_LEN_HI: begin
            held_length_in = {req_in_byte, 8'd0};
            phase_in       = irtpd_pkg::PHASE_LEN_LO;
         end
         irtpd_pkg::PHASE_LEN_LO: begin
            held_length_in = full_length;
            if (full_length == 16'd0) begin
               // zero-length packet: one empty result if the channel is routed
               has_result             = routed;
               result.payload_byte    = 8'd0;
               result.first_of_packet = 1'b1;
               result.last_of_packet  = 1'b1;
               result.empty_packet    = 1'b1;
               result.packet_length   = 16'd0;
               bytes_left_in          = 16'd0;
               phase_in               = irtpd_pkg::PHASE_HUNT;
            end else begin
               bytes_left_in = full_length;
               phase_in      = irtpd_pkg::PHASE_PAYLOAD;
            end
         end
         irtpd_pkg::PHASE_PAYLOAD: begin
            has_result = routed;
            if (last_byte) begin
               bytes_left_in = 16'd0;
               phase_in      = irtpd_pkg::PHASE_HUNT;
            end else begin
               bytes_left_in = bytes_left_ff - 16'd1;
            end
         end
         default: begin
            phase_in = (req_in_byte == irtpd_pkg::MAGIC_BYTE) ?
                       irtpd_pkg::PHASE_CHANNEL : irtpd_pkg::PHASE_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= irtpd_pkg::PHASE_HUNT;
         held_channel_ff <= 8'd0;
         held_length_ff  <= 16'd0;
         bytes_left_ff   <= 16'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         held_channel_ff <= held_channel_in;
         held_length_ff  <= held_length_in;
         bytes_left_ff   <= bytes_left_in;
      end
   end

   // output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= accept && has_result;
         end
      end else if (accept && has_result) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!main_valid_ff || !rsp_stall) begin
         main_ff <= skid_valid_ff ? skid_ff : result;
      end else if (accept && has_result) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid           = main_valid_ff;
   assign rsp_payload_byte    = main_ff.payload_byte;
   assign rsp_media_kind      = main_ff.media_kind;
   assign rsp_is_control      = main_ff.is_control;
   assign rsp_first_of_packet = main_ff.first_of_packet;
   assign rsp_last_of_packet  = main_ff.last_of_packet;
   assign rsp_empty_packet    = main_ff.empty_packet;
   assign rsp_packet_length   = main_ff.packet_length;

   skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry holds an item while the main entry is empty");

   reset_to_hunt: assert property (@(posedge clock)
      reset |=> phase_ff == irtpd_pkg::PHASE_HUNT)
      else $error("phase not hunting after reset");

   payload_count_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff == irtpd_pkg::PHASE_PAYLOAD |-> bytes_left_ff != 16'd0)
      else $error("payload phase with no bytes left");

   empty_marks: assert property (@(posedge clock) disable iff (reset)
      main_valid_ff && main_ff.empty_packet |->
         main_ff.first_of_packet && main_ff.last_of_packet && main_ff.packet_length == 16'd0)
      else $error("empty packet result with inconsistent marks");

endmodule

[tb/sv/interleaved_rtp_deframer_unit_tb.sv]
// Self-checking testbench for the interleaved RTP deframer: a directed byte table, then
// random framed streams under several channel settings, checked against a local predictor.
// Depends on irtpd_pkg and interleaved_rtp_deframer_unit.
module interleaved_rtp_deframer_unit_tb;

   localparam int unsigned DIRECTED_ROWS = 25;
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned PHASE_BYTES   = 205;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned LONG_HOLD     = 300;
   localparam int unsigned CYCLE_LIMIT   = 400000;

   typedef struct {
      logic [7:0]              in_byte;
      bit                      typed;
      bit                      has_result;
      irtpd_pkg::rsp_item_type result;
   } script_row_type;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic [7:0]                            req_in_byte;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b1;
   logic [7:0]                            rsp_payload_byte;
   logic                                  rsp_media_kind;
   logic                                  rsp_is_control;
   logic                                  rsp_first_of_packet;
   logic                                  rsp_last_of_packet;
   logic                                  rsp_empty_packet;
   logic [15:0]                           rsp_packet_length;
   logic                                  csr_write_enable;
   logic [irtpd_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [7:0]                            csr_write_data;

   // predictor state and channel registers
   irtpd_pkg::phase_type track_phase = irtpd_pkg::PHASE_HUNT;
   logic [7:0]  track_channel = 8'h00;
   logic [15:0] track_length = 16'h0000;
   logic [15:0] track_left = 16'h0000;
   logic [7:0]  route_video_data = irtpd_pkg::VIDEO_DATA_RESET;
   logic [7:0]  route_video_control = irtpd_pkg::VIDEO_CONTROL_RESET;
   logic [7:0]  route_audio_data = irtpd_pkg::AUDIO_DATA_RESET;
   logic [7:0]  route_audio_control = irtpd_pkg::AUDIO_CONTROL_RESET;

   irtpd_pkg::rsp_item_type expected_payload_q[$];
   int unsigned  fail_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  framed_bytes = 0;
   int unsigned  req_max_gap = 14;
   int unsigned  rsp_max_gap = 14;
   int unsigned  hold_requests = 0;
   int unsigned  hold_seen = 0;
   int unsigned  sink_wait_left = 0;

   script_row_type script_rows [DIRECTED_ROWS] = '{
      // noise before any magic
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b0, '0},
      // empty video data packet
      '{irtpd_pkg::MAGIC_BYTE, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{8'h00, irtpd_pkg::MEDIA_VIDEO, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0}},
      // audio control, two bytes, magic inside the payload
      '{irtpd_pkg::MAGIC_BYTE, 1'b0, 1'b0, '0},
      '{8'h03, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b1, '{8'hFF, irtpd_pkg::MEDIA_AUDIO, 1'b1, 1'b1, 1'b0, 1'b0, 16'd2}},
      '{8'h24, 1'b1, 1'b1, '{8'h24, irtpd_pkg::MEDIA_AUDIO, 1'b1, 1'b0, 1'b1, 1'b0, 16'd2}},
      // magic taken as channel, unmatched and empty: no item
      '{irtpd_pkg::MAGIC_BYTE, 1'b0, 1'b0, '0},
      '{irtpd_pkg::MAGIC_BYTE, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      // video control, one byte
      '{irtpd_pkg::MAGIC_BYTE, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h80, 1'b1, 1'b1, '{8'h80, irtpd_pkg::MEDIA_VIDEO, 1'b1, 1'b1, 1'b1, 1'b0, 16'd1}},
      // empty audio data packet
      '{irtpd_pkg::MAGIC_BYTE, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{8'h00, irtpd_pkg::MEDIA_AUDIO, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0}}
   };

   interleaved_rtp_deframer_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_in_byte         (req_in_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_media_kind      (rsp_media_kind),
      .rsp_is_control      (rsp_is_control),
      .rsp_first_of_packet (rsp_first_of_packet),
      .rsp_last_of_packet  (rsp_last_of_packet),
      .rsp_empty_packet    (rsp_empty_packet),
      .rsp_packet_length   (rsp_packet_length),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #6 clock = ~clock;

   // video is matched before audio; a control match marks the item control
   function automatic bit route_channel(output logic media, output logic control);
      media = irtpd_pkg::MEDIA_VIDEO;
      control = 1'b0;
      if (track_channel == route_video_data || track_channel == route_video_control) begin
         control = (track_channel == route_video_control);
         return 1'b1;
      end
      if (track_channel == route_audio_data || track_channel == route_audio_control) begin
         media = irtpd_pkg::MEDIA_AUDIO;
         control = (track_channel == route_audio_control);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void deframe_byte(input logic [7:0] data_byte, output bit produced,
                                        output irtpd_pkg::rsp_item_type item);
      logic media;
      logic control;
      produced = 1'b0;
      item = '0;
      case (track_phase)
         irtpd_pkg::PHASE_CHANNEL: begin
            track_channel = data_byte;
            track_phase = irtpd_pkg::PHASE_LEN_HI;
         end
         irtpd_pkg::PHASE_LEN_HI: begin
            track_length = {data_byte, 8'h00};
            track_phase = irtpd_pkg::PHASE_LEN_LO;
         end
         irtpd_pkg::PHASE_LEN_LO: begin
            track_length[7:0] = data_byte;
            if (track_length == 16'h0000) begin
               produced = route_channel(media, control);
               item = '{8'h00, media, control, 1'b1, 1'b1, 1'b1, 16'h0000};
               track_left = 16'h0000;
               track_phase = irtpd_pkg::PHASE_HUNT;
            end else begin
               track_left = track_length;
               track_phase = irtpd_pkg::PHASE_PAYLOAD;
            end
         end
         irtpd_pkg::PHASE_PAYLOAD: begin
            produced = route_channel(media, control);
            item = '{data_byte, media, control, track_left == track_length,
                     track_left <= 16'd1, 1'b0, track_length};
            if (track_left <= 16'd1) begin
               track_left = 16'h0000;
               track_phase = irtpd_pkg::PHASE_HUNT;
            end else begin
               track_left = track_left - 16'd1;
            end
         end
         default: begin
            track_phase = (data_byte == irtpd_pkg::MAGIC_BYTE) ?
                          irtpd_pkg::PHASE_CHANNEL : irtpd_pkg::PHASE_HUNT;
         end
      endcase
   endfunction

   function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_result();
      irtpd_pkg::rsp_item_type want;
      if (expected_payload_q.size() == 0) begin
         $error("unexpected item: payload_byte %0h", rsp_payload_byte);
         fail_count++;
         return;
      end
      want = expected_payload_q.pop_front();
      check_field("payload_byte", 16'(want.payload_byte), 16'(rsp_payload_byte));
      check_field("media_kind", 16'(want.media_kind), 16'(rsp_media_kind));
      check_field("is_control", 16'(want.is_control), 16'(rsp_is_control));
      check_field("first_of_packet", 16'(want.first_of_packet), 16'(rsp_first_of_packet));
      check_field("last_of_packet", 16'(want.last_of_packet), 16'(rsp_last_of_packet));
      check_field("empty_packet", 16'(want.empty_packet), 16'(rsp_empty_packet));
      check_field("packet_length", want.packet_length, rsp_packet_length);
   endfunction

   // hold the item until accepted, then predict it
   task automatic send_byte(input logic [7:0] data_byte, input bit typed = 1'b0,
                            input bit typed_has = 1'b0,
                            input irtpd_pkg::rsp_item_type typed_item = '0);
      int unsigned             gap;
      bit                      produced;
      irtpd_pkg::rsp_item_type item;
      gap = $urandom_range(0, req_max_gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= data_byte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      deframe_byte(data_byte, produced, item);
      if (typed) begin
         produced = typed_has;
         item = typed_item;
      end
      if (produced) expected_payload_q.push_back(item);
   endtask

   // mostly framed packets; some noise, foreign channels and cut-short payloads
   task automatic send_random_packet();
      int unsigned roll;
      int unsigned count;
      logic [7:0]  channel;
      logic [15:0] length;
      if ($urandom_range(0, 99) < 10) begin
         send_byte(8'($urandom_range(0, 255)));
         return;
      end
      channel = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 80) begin
         case ($urandom_range(0, 3))
            irtpd_pkg::CSR_VIDEO_DATA:    channel = route_video_data;
            irtpd_pkg::CSR_VIDEO_CONTROL: channel = route_video_control;
            irtpd_pkg::CSR_AUDIO_DATA:    channel = route_audio_data;
            default:                      channel = route_audio_control;
         endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) length = 16'd0;
      else if (roll < 97) length = 16'($urandom_range(1, 24));
      else length = 16'($urandom_range(25, 400));
      count = length;
      if (length != 0 && $urandom_range(0, 99) < 5) count = $urandom_range(0, length - 1);
      send_byte(irtpd_pkg::MAGIC_BYTE);
      send_byte(channel);
      send_byte(length[15:8]);
      send_byte(length[7:0]);
      repeat (count) send_byte(8'($urandom_range(0, 255)));
      framed_bytes += 4 + count;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_payload_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_channel_reg(input logic [irtpd_pkg::CSR_INDEX_WIDTH-1:0] index,
                                    input logic [7:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      case (index)
         irtpd_pkg::CSR_VIDEO_DATA:    route_video_data = data;
         irtpd_pkg::CSR_VIDEO_CONTROL: route_video_control = data;
         irtpd_pkg::CSR_AUDIO_DATA:    route_audio_data = data;
         irtpd_pkg::CSR_AUDIO_CONTROL: route_audio_control = data;
         default: ;
      endcase
   endtask

   task automatic load_channel_plan(input logic [7:0] video_data, input logic [7:0] video_control,
                                    input logic [7:0] audio_data, input logic [7:0] audio_control);
      drain_results();
      write_channel_reg(irtpd_pkg::CSR_VIDEO_DATA, video_data);
      write_channel_reg(irtpd_pkg::CSR_VIDEO_CONTROL, video_control);
      write_channel_reg(irtpd_pkg::CSR_AUDIO_DATA, audio_data);
      write_channel_reg(irtpd_pkg::CSR_AUDIO_CONTROL, audio_control);
      // indexes past the four registers must be ignored
      for (int idx = int'(irtpd_pkg::CSR_AUDIO_CONTROL) + 1;
           idx < (1 << irtpd_pkg::CSR_INDEX_WIDTH); idx++)
         write_channel_reg((irtpd_pkg::CSR_INDEX_WIDTH)'(idx), 8'($urandom_range(0, 255)));
      csr_write_enable <= 1'b0;
   endtask

   always @(posedge clock) begin : result_sink
      int unsigned next_wait;
      if (reset) begin
         rsp_stall <= 1'b1;
         sink_wait_left <= 0;
         hold_seen <= hold_requests;
      end else begin
         next_wait = sink_wait_left;
         if (rsp_valid && !rsp_stall) begin
            check_result();
            next_wait = $urandom_range(0, rsp_max_gap);
         end
         if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            next_wait = LONG_HOLD;
         end
         rsp_stall <= (next_wait != 0);
         sink_wait_left <= (next_wait != 0) ? next_wait - 1 : 0;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      csr_write_enable = 1'b0;
      csr_index = irtpd_pkg::CSR_VIDEO_DATA;
      csr_write_data = 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (script_rows[row])
         send_byte(script_rows[row].in_byte, script_rows[row].typed,
                   script_rows[row].has_result, script_rows[row].result);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: load_channel_plan(8'hFF, 8'hFF, 8'h00, 8'h00);
            1: load_channel_plan(8'h00, 8'h00, 8'h00, 8'h00);
            2: load_channel_plan(8'hFF, 8'h00, 8'hFF, 8'h80);
            default: load_channel_plan(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         endcase
         // phase 3 runs back to back; phase 4 floods the block while the sink holds off
         req_max_gap = (phase == 3 || phase == 4) ? 0 : 14;
         rsp_max_gap <= (phase == 3) ? 0 : 14;
         if (phase == 4) hold_requests <= hold_requests + 1;
         framed_bytes = 0;
         while (framed_bytes < PHASE_BYTES) send_random_packet();
      end

      drain_results();
      if (fail_count == 0 && expected_payload_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
